[hdl/jsu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Shared types, character codes and small decode functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam logic [7:0]  CH_QUOTE     = 8'h22;
    localparam logic [7:0]  CH_BSLASH    = 8'h5C;
    localparam logic [7:0]  CH_U         = 8'h75;

    localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;
    localparam logic [15:0] UTF8_ONE_LIM = 16'h0080;
    localparam logic [15:0] UTF8_TWO_LIM = 16'h0800;

    localparam int unsigned MAX_RES      = 4;
    localparam int unsigned RES_IDX_W    = $clog2(MAX_RES);
    localparam int unsigned RES_CNT_W    = $clog2(MAX_RES + 1);

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_BODY = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
    } t_entry;

    // Results caused by one source byte, handed from the decoder to the
    // serializer in the cycle the byte is consumed.
    typedef struct packed {
        logic                 valid;
        logic [RES_CNT_W-1:0] cnt;
        t_entry [MAX_RES-1:0] ent;
    } t_bundle;

    function automatic logic [7:0] escape_map(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            default: r = e;
        endcase
        return r;
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] h);
        logic [4:0] r;
        if (h >= 8'h30 && h <= 8'h39) begin
            r = {1'b1, 4'(h - 8'h30)};
        end else if (h >= 8'h61 && h <= 8'h66) begin
            r = {1'b1, 4'(h - 8'h57)};
        end else if (h >= 8'h41 && h <= 8'h46) begin
            r = {1'b1, 4'(h - 8'h37)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/jsu_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescaper decoder
// Input register, parse state and the decode of one byte into its results.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire logic [7:0]      i_s_tdata,
    input  wire logic            i_s_tlast,
    input  wire logic            i_free,
    output jsu_pkg::t_bundle     o_bundle
);
    import jsu_pkg::*;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;

    t_phase               r_phase, n_phase;
    logic [1:0]           r_hex_cnt, n_hex_cnt;
    logic [11:0]          r_cp, n_cp;

    logic                 consume;
    logic                 closed;
    logic                 failed;
    logic [4:0]           hexv;
    logic [15:0]          cp_full;
    logic [RES_CNT_W-1:0] n;
    t_entry [MAX_RES-1:0] ent;

    assign consume    = r_in_valid && i_free;
    assign o_s_tready = !r_in_valid || i_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_hex_cnt <= 2'd0;
            r_cp      <= 12'd0;
        end else if (consume) begin
            r_phase   <= n_phase;
            r_hex_cnt <= n_hex_cnt;
            r_cp      <= n_cp;
        end
    end

    assign hexv    = hex_value(r_in_byte);
    assign cp_full = {r_cp, hexv[3:0]};

    always_comb begin
        n_phase   = r_phase;
        n_hex_cnt = r_hex_cnt;
        n_cp      = r_cp;
        closed    = 1'b0;
        failed    = 1'b0;
        n         = '0;
        ent       = '0;

        case (r_phase)
            PH_BODY: begin
                if (r_in_byte == CH_QUOTE) begin
                    ent[n[RES_IDX_W-1:0]] = '{data: 8'd0, status: ST_DONE};
                    n      = n + 1'b1;
                    closed = 1'b1;
                end else if (r_in_byte == CH_BSLASH) begin
                    if (r_in_last) begin
                        // A trailing backslash is kept as a literal one.
                        ent[n[RES_IDX_W-1:0]] = '{data: CH_BSLASH, status: ST_DATA};
                        n = n + 1'b1;
                    end else begin
                        n_phase = PH_ESC;
                    end
                end else if (!r_in_last) begin
                    ent[n[RES_IDX_W-1:0]] = '{data: r_in_byte, status: ST_DATA};
                    n = n + 1'b1;
                end
            end
            PH_ESC: begin
                if (r_in_byte == CH_U) begin
                    n_phase   = PH_HEX;
                    n_hex_cnt = 2'd0;
                    n_cp      = 12'd0;
                end else begin
                    ent[n[RES_IDX_W-1:0]] = '{data: escape_map(r_in_byte),
                                             status: ST_DATA};
                    n       = n + 1'b1;
                    n_phase = PH_BODY;
                end
            end
            PH_HEX: begin
                if (!hexv[4]) begin
                    failed = 1'b1;
                end else if (r_hex_cnt == 2'd3) begin
                    if (cp_full < UTF8_ONE_LIM) begin
                        ent[n[RES_IDX_W-1:0]] = '{data: cp_full[7:0], status: ST_DATA};
                        n = n + 1'b1;
                    end else if (cp_full < UTF8_TWO_LIM) begin
                        ent[n[RES_IDX_W-1:0]] = '{data: UTF8_LEAD2 | {3'd0, cp_full[10:6]},
                                                 status: ST_DATA};
                        n = n + 1'b1;
                        ent[n[RES_IDX_W-1:0]] = '{data: UTF8_CONT | {2'd0, cp_full[5:0]},
                                                 status: ST_DATA};
                        n = n + 1'b1;
                    end else begin
                        ent[n[RES_IDX_W-1:0]] = '{data: UTF8_LEAD3 | {4'd0, cp_full[15:12]},
                                                 status: ST_DATA};
                        n = n + 1'b1;
                        ent[n[RES_IDX_W-1:0]] = '{data: UTF8_CONT | {2'd0, cp_full[11:6]},
                                                 status: ST_DATA};
                        n = n + 1'b1;
                        ent[n[RES_IDX_W-1:0]] = '{data: UTF8_CONT | {2'd0, cp_full[5:0]},
                                                 status: ST_DATA};
                        n = n + 1'b1;
                    end
                    n_hex_cnt = 2'd0;
                    n_cp      = 12'd0;
                    n_phase   = PH_BODY;
                end else begin
                    n_cp      = cp_full[11:0];
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end
            end
            default: begin
                if (r_in_byte == CH_QUOTE) begin
                    n_phase   = PH_BODY;
                    n_hex_cnt = 2'd0;
                    n_cp      = 12'd0;
                end else begin
                    failed = 1'b1;
                end
            end
        endcase

        // A source that ends while a string is open is an error after the
        // byte itself has been decoded.
        if (closed) begin
            n_phase   = PH_WAIT;
            n_hex_cnt = 2'd0;
            n_cp      = 12'd0;
        end else if (failed || (r_in_last && n_phase != PH_WAIT)) begin
            ent[n[RES_IDX_W-1:0]] = '{data: 8'd0, status: ST_ERR};
            n         = n + 1'b1;
            n_phase   = PH_WAIT;
            n_hex_cnt = 2'd0;
            n_cp      = 12'd0;
        end
    end

    assign o_bundle = '{valid: consume, cnt: n, ent: ent};

endmodule
`default_nettype wire

[hdl/jsu_serial.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescaper result serializer
// Holds the results of one byte and sends them through the output register.
// ----------------------------------------------------------------------------
module jsu_serial (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire jsu_pkg::t_bundle i_bundle,
    output logic                  o_free,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [7:0]            o_m_tdata,
    output logic [1:0]            o_m_tuser,
    output logic                  o_m_tlast
);
    import jsu_pkg::*;

    t_entry [MAX_RES-1:0] r_ent;
    logic [RES_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    logic [7:0]           r_out_data;
    t_status              r_out_status;
    logic                 r_out_last;

    logic                 out_load;
    logic                 pop;

    assign out_load = !r_out_valid || i_m_tready;
    assign pop      = out_load && (r_cnt != '0);
    assign o_free   = (r_cnt == '0) || ((r_cnt == RES_CNT_W'(1)) && out_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_bundle.valid) begin
            r_cnt <= i_bundle.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Entries shift down so the next result always sits at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_bundle.valid) begin
            r_ent <= i_bundle.ent;
        end else if (pop) begin
            r_ent <= {t_entry'('0), r_ent[MAX_RES-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_data   <= r_ent[0].data;
            r_out_status <= r_ent[0].status;
            r_out_last   <= (r_cnt == RES_CNT_W'(1));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

[hdl/json_string_unescaper.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescaper
// Decodes a quoted JSON string from a byte stream into raw and UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one source byte per item in tdata, with tlast set
//   on the final byte of the source. The master channel gives one result per
//   item: tdata is the decoded byte, tuser the status (data, string closed,
//   parse error) and tlast marks the final result caused by one source byte.
//   A source byte may cause no result at all, or up to four.
//   The first result of a byte passes through the input register, the decode
//   into the result buffer and the output register. Throughput: one source
//   byte per cycle while each byte causes at most one result and the
//   receiver does not stall; a byte with more results holds the input until
//   the single output register takes the last of them from the result buffer.
//   Reset clears the input, buffer and output valids and puts the parser in
//   the state that waits for an opening quote.
//   When the receiver stalls, the output holds its item, the buffer fills
//   and tready on the slave side drops until the buffer frees up.
// ----------------------------------------------------------------------------
module json_string_unescaper (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tlast,   // end_of_source
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic [1:0]      o_m_tuser,   // [1:0] status
    output logic            o_m_tlast    // last_of_run
);
    import jsu_pkg::*;

    t_bundle bundle;
    logic    free;

    jsu_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_free     (free),
        .o_bundle   (bundle)
    );

    jsu_serial u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bundle   (bundle),
        .o_free     (free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire
